// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/mqrrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mqrrs_pkg;

  // Fixed field widths of the command, result and configuration ports.
  localparam int OpW        = 1;
  localparam int PortFieldW = 3;
  localparam int PayloadW   = 32;
  localparam int StatusW    = 3;
  localparam int CfgW       = 8;

  // Default sizing.
  localparam int NumPortsDef     = 8;
  localparam int QueueDepthDef   = 16;
  localparam int PayloadWidthDef = 32;

  localparam logic [OpW-1:0] OP_SEND = 1'b0;
  localparam logic [OpW-1:0] OP_PULL = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPTED    = 3'd0,
    ST_UNKNOWN_SRC = 3'd1,
    ST_UNKNOWN_DST = 3'd2,
    ST_FULL        = 3'd3,
    ST_DELIVERED   = 3'd4,
    ST_EMPTY       = 3'd5
  } status_e;

endpackage

`default_nettype wire

// File: rtl/mqrrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mqrrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/multi_queue_round_robin_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Round-robin scheduler over one message queue per port.
// Command channel: a command is taken at a rising edge with start high and
// busy low. op selects send (enqueue payload on dest_port's queue, both
// source and destination ports must be enabled) or pull (serve the first
// enabled, non-empty queue at or after the round-robin pointer).
// Result channel: done_o is high for exactly one cycle, the cycle right
// after the command beat, with status, served port and message. The
// receiver cannot stall, so results are never held back.
// A new command can be taken every cycle: the
// payload store is a single RAM with a registered read, and the
// per-port head, tail and fill counters sit in flops next to a priority
// encoder, so each command is one RAM access. busy stays low.
// Configuration: enabled_ports_i is written on a cfg_valid_i/cfg_ready_o
// beat; ready drops while a command is offered. Clearing a port's bit
// empties its queue.
// Reset clears the enable mask, all queue counters and the pointer; the
// payload RAM is not cleared since only written entries are ever read.
module multi_queue_round_robin_scheduler_top #(
  parameter int NUM_PORTS     = mqrrs_pkg::NumPortsDef,
  parameter int QUEUE_DEPTH   = mqrrs_pkg::QueueDepthDef,
  parameter int PAYLOAD_WIDTH = mqrrs_pkg::PayloadWidthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire logic [mqrrs_pkg::OpW-1:0]          op_i,
  input  wire logic [mqrrs_pkg::PortFieldW-1:0]   source_port_i,
  input  wire logic [mqrrs_pkg::PortFieldW-1:0]   dest_port_i,
  input  wire logic [mqrrs_pkg::PayloadW-1:0]     payload_i,
  output      logic                               done_o,
  output      logic [mqrrs_pkg::StatusW-1:0]      status_o,
  output      logic [mqrrs_pkg::PortFieldW-1:0]   served_port_o,
  output      logic [mqrrs_pkg::PayloadW-1:0]     message_out_o,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [mqrrs_pkg::CfgW-1:0]         enabled_ports_i
);

  import mqrrs_pkg::*;

  localparam int PW    = $clog2(NUM_PORTS);
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int Depth = NUM_PORTS * QUEUE_DEPTH;
  localparam int AW    = $clog2(Depth);

  localparam logic [AW-1:0] QdA     = AW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] CntFull = CW'(QUEUE_DEPTH);
  localparam logic [QW-1:0] LastIdx = QW'(QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] LastPrt = PW'(NUM_PORTS - 1);

  logic [NUM_PORTS-1:0] en_q, en_d;
  logic [QW-1:0]        head_q [NUM_PORTS];
  logic [QW-1:0]        head_d [NUM_PORTS];
  logic [QW-1:0]        tail_q [NUM_PORTS];
  logic [QW-1:0]        tail_d [NUM_PORTS];
  logic [CW-1:0]        cnt_q  [NUM_PORTS];
  logic [CW-1:0]        cnt_d  [NUM_PORTS];
  logic [PW-1:0]        rr_q, rr_d;
  logic                 done_q;
  status_e              status_q, status_d;
  logic [PW-1:0]        served_q, served_d;

  logic                     cmd_fire, cfg_fire;
  logic [CfgW-1:0]          en_view;
  logic [NUM_PORTS-1:0]     cfg_en;
  logic                     src_on, dst_on;
  logic [PW-1:0]            dst_idx;
  logic [NUM_PORTS-1:0]     req, req_hi;
  logic [PW-1:0]            pick_lo, pick_hi, pick;
  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic [PAYLOAD_WIDTH-1:0] wdata, rdata;

  assign busy        = 1'b0;
  assign cmd_fire    = start && !busy;
  assign cfg_ready_o = !start;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Enable mask widened to 8 bits for the 3-bit port fields, and the mask a
  // configuration beat would load.
  for (genvar g = 0; g < CfgW; g++) begin : g_view
    if (g < NUM_PORTS) begin : g_in
      assign en_view[g] = en_q[g];
    end else begin : g_out
      assign en_view[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_cfg
    if (g < CfgW) begin : g_in
      assign cfg_en[g] = enabled_ports_i[g];
    end else begin : g_out
      assign cfg_en[g] = 1'b0;
    end
  end

  assign src_on  = en_view[source_port_i];
  assign dst_on  = en_view[dest_port_i];
  assign dst_idx = PW'(dest_port_i);
  assign wdata   = PAYLOAD_WIDTH'(payload_i);

  // Round-robin pick: lowest requester at or above the pointer, else the
  // lowest requester overall.
  always_comb begin
    pick_lo = '0;
    pick_hi = '0;
    for (int p = NUM_PORTS - 1; p >= 0; p--) begin
      req[p]    = en_q[p] && (cnt_q[p] != '0);
      req_hi[p] = req[p] && (PW'(p) >= rr_q);
      if (req[p]) begin
        pick_lo = PW'(p);
      end
      if (req_hi[p]) begin
        pick_hi = PW'(p);
      end
    end
    pick = (|req_hi) ? pick_hi : pick_lo;
  end

  always_comb begin
    en_d     = en_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    rr_d     = rr_q;
    status_d = status_q;
    served_d = served_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = AW'(dst_idx) * QdA + AW'(tail_q[dst_idx]);
    raddr    = AW'(pick) * QdA + AW'(head_q[pick]);

    if (cfg_fire) begin
      en_d = cfg_en;
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (!cfg_en[p]) begin
          head_d[p] = '0;
          tail_d[p] = '0;
          cnt_d[p]  = '0;
        end
      end
    end

    if (cmd_fire) begin
      served_d = '0;
      if (op_i == OP_SEND) begin
        if (!src_on) begin
          status_d = ST_UNKNOWN_SRC;
        end else if (!dst_on) begin
          status_d = ST_UNKNOWN_DST;
        end else if (cnt_q[dst_idx] == CntFull) begin
          status_d = ST_FULL;
        end else begin
          we              = 1'b1;
          tail_d[dst_idx] = (tail_q[dst_idx] == LastIdx) ? '0 : tail_q[dst_idx] + QW'(1);
          cnt_d[dst_idx]  = cnt_q[dst_idx] + CW'(1);
          status_d        = ST_ACCEPTED;
        end
      end else if (|req) begin
        re           = 1'b1;
        head_d[pick] = (head_q[pick] == LastIdx) ? '0 : head_q[pick] + QW'(1);
        cnt_d[pick]  = cnt_q[pick] - CW'(1);
        served_d     = pick;
        status_d     = ST_DELIVERED;
        rr_d         = (pick == LastPrt) ? '0 : pick + PW'(1);
      end else begin
        status_d = ST_EMPTY;
        rr_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= '0;
      rr_q   <= '0;
      done_q <= 1'b0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        head_q[p] <= '0;
        tail_q[p] <= '0;
        cnt_q[p]  <= '0;
      end
    end else begin
      en_q   <= en_d;
      rr_q   <= rr_d;
      done_q <= cmd_fire;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    served_q <= served_d;
  end

  mqrrs_ram #(
    .WIDTH(PAYLOAD_WIDTH),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign served_port_o = PortFieldW'(served_q);
  assign message_out_o = (status_q == ST_DELIVERED) ? PayloadW'(rdata) : '0;

endmodule

`default_nettype wire

// File: rtl/mqrrs_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mqrrs_chk (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic [mqrrs_pkg::OpW-1:0]          op_i,
  input wire logic                               done_o,
  input wire logic [mqrrs_pkg::StatusW-1:0]      status_o,
  input wire logic [mqrrs_pkg::PortFieldW-1:0]   served_port_o,
  input wire logic [mqrrs_pkg::PayloadW-1:0]     message_out_o
);

  import mqrrs_pkg::*;

  logic cmd_beat;
  logic not_delivered;

  assign cmd_beat      = start && !busy;
  assign not_delivered = status_o != ST_DELIVERED;

  // Every command gives exactly one result, in the following cycle.
  `ASSERT_NXT(a_result_follows, cmd_beat, done_o)
  `ASSERT_NXT(a_no_spurious_result, !cmd_beat, !done_o)

  // A send never reports a pull outcome and a pull never a send outcome.
  `ASSERT_NXT(a_send_status, cmd_beat && (op_i == OP_SEND),
              (status_o != ST_DELIVERED) && (status_o != ST_EMPTY))
  `ASSERT_NXT(a_pull_status, cmd_beat && (op_i == OP_PULL),
              (status_o == ST_DELIVERED) || (status_o == ST_EMPTY))

  // Without a delivery the port and message fields read as zero.
  `ASSERT_IMP(a_idle_fields_zero, done_o && not_delivered,
              (served_port_o == '0) && (message_out_o == '0))

endmodule

bind multi_queue_round_robin_scheduler_top mqrrs_chk u_mqrrs_chk (.*);

`default_nettype wire
